/* hdl/online_perceptron_trainer_macros.svh */
// ---------------------------------------------------------------------------
// online_perceptron_trainer_macros.svh
// Assertion helpers for the perceptron trainer. Both expect clk_i and rst_ni
// in scope. Compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ONLINE_PERCEPTRON_TRAINER_MACROS_SVH
`define ONLINE_PERCEPTRON_TRAINER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define OPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OPT_ASSERT_NOW(lbl, ante, cons, msg)
`define OPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/opt_pkg.sv */
// ---------------------------------------------------------------------------
// opt_pkg
// Shared widths, codes, chain types and saturation for the perceptron trainer.
// ---------------------------------------------------------------------------
`default_nettype none

package opt_pkg;

  localparam int DIM        = 8;
  localparam int NUM_FEAT   = 8;
  localparam int FEAT_W     = 16;
  localparam int W_W        = 32;
  localparam int FRAC_SH    = 8;
  localparam int LR_W       = 16;
  localparam int MODE_W     = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = W_W + FEAT_W + $clog2(DIM + 1);
  localparam int SAT_W      = ACC_W - FRAC_SH;
  localparam int ERR_W      = W_W + 1;
  localparam int RP_W       = ERR_W + LR_W + 1;
  localparam int RE_W       = RP_W - LR_W;
  localparam int PROD_W     = RE_W + FEAT_W;
  localparam int STATE_W    = 3;

  localparam logic [LR_W-1:0]   LR_RESET   = LR_W'(655);
  localparam logic [W_W-1:0]    Q_ONE      = W_W'(65536);
  localparam logic [W_W-1:0]    Q_MINUS    = ~Q_ONE + W_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_RAW   = 2'd0,
    CMD_ACT   = 2'd1,
    CMD_TRAIN = 2'd2
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    ACT_IDENTITY = 2'd0,
    ACT_STEP     = 2'd1,
    ACT_SIGN     = 2'd2
  } act_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE   = 1'b0,
    REG_ACTIVATION_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic [STATE_W-1:0] {
    S_IDLE,
    S_DOT,
    S_ACT,
    S_OUT,
    S_ERR,
    S_MUL,
    S_UPD
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_upd;
    logic apply;
  } cell_ctrl_t;

  typedef struct packed {
    logic             tok;
    logic [ACC_W-1:0] sum;
  } link_t;

  function automatic logic [W_W-1:0] sat_w(input logic [SAT_W-1:0] v);
    logic [SAT_W-W_W:0] top;
    logic [W_W-1:0]     r;
    top = v[SAT_W-1:W_W-1];
    if (top == '0 || top == '1) begin
      r = v[W_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/opt_cell.sv */
// ---------------------------------------------------------------------------
// opt_cell
// One weight of the perceptron: multiplies its weight or the scaled error by
// its feature, adds its product to the partial sum passing down the chain,
// and applies its saturating weight update.
// ---------------------------------------------------------------------------
`default_nettype none

module opt_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  opt_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]   feature_i,
  input  logic signed [opt_pkg::RE_W-1:0]     re_i,
  input  opt_pkg::link_t                      link_i,
  output opt_pkg::link_t                      link_o
);
  import opt_pkg::*;

  logic signed [W_W-1:0]    w_q, w_d;
  logic signed [FEAT_W-1:0] feat_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [RE_W-1:0]   mul_a;
  logic signed [FEAT_W-1:0] mul_b;
  logic                     tok_q;
  logic [ACC_W-1:0]         sum_q;
  logic [SAT_W-1:0]         upd_sum;

  assign mul_a  = ctrl_i.load ? {{(RE_W-W_W){w_q[W_W-1]}}, w_q} : re_i;
  assign mul_b  = ctrl_i.load ? feature_i : feat_q;
  assign prod_d = mul_a * mul_b;

  // weight + floor(prod / 256)
  assign upd_sum = {{(SAT_W-W_W){w_q[W_W-1]}}, w_q}
                 + {{(SAT_W-PROD_W+FRAC_SH){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:FRAC_SH]};

  always_comb begin
    w_d = w_q;
    if (ctrl_i.apply) begin
      w_d = sat_w(upd_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= '0;
      tok_q <= 1'b0;
    end else begin
      w_q   <= w_d;
      tok_q <= link_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      feat_q <= feature_i;
    end
    if (ctrl_i.load || ctrl_i.mul_upd) begin
      prod_q <= prod_d;
    end
    if (link_i.tok) begin
      sum_q <= link_i.sum + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign link_o.tok = tok_q;
  assign link_o.sum = sum_q;

endmodule

`default_nettype wire

/* hdl/online_perceptron_trainer.sv */
// ---------------------------------------------------------------------------
// online_perceptron_trainer
// Single-layer perceptron with online delta-rule training, built as a chain
// of weight cells that pass the partial dot product from one to the next.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item: cmd, eight Q8.8
//   features and a Q16.16 target. Output channel (out_valid_o/out_ready_i)
//   returns one item per input: result_value and raw_sum.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes learning_rate
//   (index 0) or activation_mode (index 1); write while idle.
//   Flow: the sum ripples through the DIM cells in turn, each adding its
//   product to the partial sum. The result then passes the activation
//   register and the output register. A train item then holds off the input
//   while the error is scaled, each cell multiplies and the weights are
//   written; a new item is taken only once the sequencer is idle again.
//   A result waiting in the output register does not block the next accept;
//   the sequencer only stalls once its own result finds that register full.
//   Reset: weights and bias clear to zero, learning_rate 655, mode step.
// ---------------------------------------------------------------------------
`default_nettype none

module online_perceptron_trainer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [opt_pkg::CMD_W-1:0]             cmd_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_0_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_1_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_2_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_3_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_4_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_5_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_6_i,
  input  logic signed [opt_pkg::FEAT_W-1:0]     feature_7_i,
  input  logic signed [opt_pkg::W_W-1:0]        target_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [opt_pkg::W_W-1:0]        result_value_o,
  output logic signed [opt_pkg::W_W-1:0]        raw_sum_o,
  input  logic                                  cfg_we_i,
  input  logic [opt_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [opt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import opt_pkg::*;

  `include "online_perceptron_trainer_macros.svh"

  state_e                   state_q, state_d;
  cell_ctrl_t               ctrl;
  logic                     start_q;
  logic                     accept;
  logic                     act_load, out_load, err_load, bias_load;
  logic [CMD_W-1:0]         cmd_q;
  logic signed [W_W-1:0]    target_q;
  logic signed [W_W-1:0]    raw_q, act_q, raw_d, act_d;
  logic signed [RE_W-1:0]   re_q;
  logic signed [W_W-1:0]    bias_q;
  logic [LR_W-1:0]          lr_q;
  logic [MODE_W-1:0]        mode_q;
  logic                     out_valid_q;
  logic signed [W_W-1:0]    out_result_q, out_raw_q;
  logic signed [ERR_W-1:0]  err;
  logic signed [RP_W-1:0]   rate_prod;
  logic [SAT_W-1:0]         bias_sum;
  logic signed [FEAT_W-1:0] feat_in [NUM_FEAT];
  link_t                    chain [DIM+1];

  assign feat_in[0] = feature_0_i;
  assign feat_in[1] = feature_1_i;
  assign feat_in[2] = feature_2_i;
  assign feat_in[3] = feature_3_i;
  assign feat_in[4] = feature_4_i;
  assign feat_in[5] = feature_5_i;
  assign feat_in[6] = feature_6_i;
  assign feat_in[7] = feature_7_i;

  // head of chain: bias aligned to Q28.24
  assign chain[0].tok = start_q;
  assign chain[0].sum = {{(ACC_W-W_W-FRAC_SH){bias_q[W_W-1]}}, bias_q, {FRAC_SH{1'b0}}};

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    opt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .feature_i (feat_in[k]),
      .re_i      (re_q),
      .link_i    (chain[k]),
      .link_o    (chain[k+1])
    );
  end

  // activation
  always_comb begin
    raw_d = sat_w(chain[DIM].sum[ACC_W-1:FRAC_SH]);
    unique case (mode_q)
      ACT_STEP: act_d = raw_d[W_W-1] ? '0 : Q_ONE;
      ACT_SIGN: act_d = raw_d[W_W-1] ? Q_MINUS : Q_ONE;
      default:  act_d = raw_d;
    endcase
  end

  assign err       = {target_q[W_W-1], target_q} - {act_q[W_W-1], act_q};
  assign rate_prod = $signed({1'b0, lr_q}) * err;
  assign bias_sum  = {{(SAT_W-W_W){bias_q[W_W-1]}}, bias_q}
                   + {{(SAT_W-RE_W){re_q[RE_W-1]}}, re_q};

  // sequencer
  always_comb begin
    state_d    = state_q;
    ctrl       = '0;
    in_ready_o = 1'b0;
    act_load   = 1'b0;
    out_load   = 1'b0;
    err_load   = 1'b0;
    bias_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl.load = 1'b1;
          state_d   = S_DOT;
        end
      end
      S_DOT: begin
        if (chain[DIM].tok) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        act_load = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = (cmd_q == CMD_TRAIN) ? S_ERR : S_IDLE;
        end
      end
      S_ERR: begin
        err_load = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        ctrl.mul_upd = 1'b1;
        bias_load    = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        ctrl.apply = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      bias_q      <= '0;
      lr_q        <= LR_RESET;
      mode_q      <= ACT_STEP;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (bias_load) begin
        bias_q <= sat_w(bias_sum);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LEARNING_RATE:   lr_q   <= cfg_data_i[LR_W-1:0];
          REG_ACTIVATION_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      target_q <= target_i;
    end
    if (act_load) begin
      raw_q <= raw_d;
      act_q <= act_d;
    end
    if (out_load) begin
      out_result_q <= (cmd_q == CMD_RAW) ? raw_q : act_q;
      out_raw_q    <= raw_q;
    end
    if (err_load) begin
      re_q <= rate_prod[RP_W-1:LR_W];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_result_q;
  assign raw_sum_o      = out_raw_q;

  `OPT_ASSERT_NEXT(a_accept_starts_chain, accept, start_q && state_q == S_DOT, "accept did not start chain")
  `OPT_ASSERT_NOW(a_tok_only_in_dot, chain[DIM].tok, state_q == S_DOT, "sum left chain outside dot phase")
  `OPT_ASSERT_NEXT(a_bias_hold, state_q != S_MUL, $stable(bias_q), "bias changed outside update")
  `OPT_ASSERT_NOW(a_update_only_train, state_q == S_ERR, cmd_q == CMD_TRAIN, "update on non-train item")

endmodule

`default_nettype wire

/* tb/sv/online_perceptron_trainer_tb.sv */
// ---------------------------------------------------------------------------
// online_perceptron_trainer_tb
// Self-checking bench for the perceptron trainer. A shadow copy of weights,
// bias, rate and mode predicts every result item; directed cases hit the
// saturation corners, every command and activation mode, then random traffic
// runs under several register settings with idling and back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module online_perceptron_trainer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 2 * DIM + 8;

  localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic signed [FEAT_W-1:0] F_MAX = 16'sh7FFF;
  localparam logic signed [FEAT_W-1:0] F_MIN = 16'sh8000;
  localparam logic signed [W_W-1:0]    T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [W_W-1:0]    T_MIN = 32'sh8000_0000;

  typedef logic signed [FEAT_W-1:0] feat_set_t [NUM_FEAT];

  typedef struct packed {
    logic signed [W_W-1:0] value;
    logic signed [W_W-1:0] raw;
  } score_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready;
  logic [CMD_W-1:0]             cmd_drv;
  logic signed [FEAT_W-1:0]     feat_drv [NUM_FEAT];
  logic signed [W_W-1:0]        target_drv;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [W_W-1:0]        result_value;
  logic signed [W_W-1:0]        raw_sum;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_idx;
  logic [CFG_DATA_W-1:0]        cfg_data;

  logic signed [W_W-1:0]        shadow_w [NUM_FEAT];
  logic signed [W_W-1:0]        shadow_bias;
  logic [LR_W-1:0]              shadow_rate;
  logic [MODE_W-1:0]            shadow_mode;

  score_t                       pending_scores [$];
  score_t                       got_want;
  int                           errors = 0;
  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  int                           hold_request = 0;
  int                           stall_left = 0;
  int                           cycle_count = 0;

  always #6ns clk_i = ~clk_i;

  online_perceptron_trainer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd_drv),
    .feature_0_i    (feat_drv[0]),
    .feature_1_i    (feat_drv[1]),
    .feature_2_i    (feat_drv[2]),
    .feature_3_i    (feat_drv[3]),
    .feature_4_i    (feat_drv[4]),
    .feature_5_i    (feat_drv[5]),
    .feature_6_i    (feat_drv[6]),
    .feature_7_i    (feat_drv[7]),
    .target_i       (target_drv),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .raw_sum_o      (raw_sum),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  function automatic logic signed [W_W-1:0] clamp_q16(input longint v);
    if (v > longint'(T_MAX)) begin
      return T_MAX;
    end else if (v < longint'(T_MIN)) begin
      return T_MIN;
    end
    return v[W_W-1:0];
  endfunction

  // dot product + bias, activation, then delta-rule update on train
  function automatic void score_and_learn(input logic [CMD_W-1:0] cmd,
                                          input feat_set_t x,
                                          input logic signed [W_W-1:0] target,
                                          output score_t s);
    longint                acc;
    longint                err;
    longint                scaled;
    longint                delta;
    logic signed [W_W-1:0] act;
    acc = longint'(shadow_bias) * 256;
    for (int i = 0; i < DIM; i++) begin
      acc += longint'(shadow_w[i]) * longint'(x[i]);
    end
    s.raw = clamp_q16(acc >>> FRAC_SH);
    case (shadow_mode)
      ACT_STEP: act = (s.raw >= 0) ? Q_ONE : '0;
      ACT_SIGN: act = (s.raw >= 0) ? Q_ONE : Q_MINUS;
      default:  act = s.raw;
    endcase
    s.value = (cmd == CMD_RAW) ? s.raw : act;
    if (cmd == CMD_TRAIN) begin
      err    = longint'(target) - longint'(act);
      scaled = (longint'(shadow_rate) * err) >>> 16;
      for (int i = 0; i < DIM; i++) begin
        delta       = (scaled * longint'(x[i])) >>> FRAC_SH;
        shadow_w[i] = clamp_q16(longint'(shadow_w[i]) + delta);
      end
      shadow_bias = clamp_q16(longint'(shadow_bias) + scaled);
    end
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input feat_set_t x,
                           input logic signed [W_W-1:0] target);
    score_t s;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    cmd_drv    <= cmd;
    target_drv <= target;
    for (int i = 0; i < NUM_FEAT; i++) begin
      feat_drv[i] <= x[i];
    end
    do @(posedge clk_i); while (!in_ready);
    score_and_learn(cmd, x, target, s);
    pending_scores.push_back(s);
  endtask

  task automatic send_pattern(input logic [CMD_W-1:0] cmd,
                              input logic signed [FEAT_W-1:0] even_v,
                              input logic signed [FEAT_W-1:0] odd_v,
                              input logic signed [W_W-1:0] target);
    feat_set_t x;
    for (int i = 0; i < NUM_FEAT; i++) begin
      x[i] = i[0] ? odd_v : even_v;
    end
    send_item(cmd, x, target);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      REG_LEARNING_RATE:   shadow_rate = data[LR_W-1:0];
      REG_ACTIVATION_MODE: shadow_mode = data[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // drop valid, wait for every result, then let a train update finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic signed [FEAT_W-1:0] rand_feature();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 65) begin
      v = int'($urandom_range(2048)) - 1024;
      return v[FEAT_W-1:0];
    end else if (pick < 88) begin
      return FEAT_W'($urandom);
    end
    case ($urandom_range(3))
      0:       return F_MAX;
      1:       return F_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [W_W-1:0] rand_target();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      case (shadow_mode)
        ACT_STEP: return $urandom_range(1) ? Q_ONE : '0;
        ACT_SIGN: return $urandom_range(1) ? Q_ONE : Q_MINUS;
        default: begin
          v = int'($urandom_range(1 << 18)) - (1 << 17);
          return v;
        end
      endcase
    end else if (pick < 85) begin
      v = int'($urandom_range(1 << 21)) - (1 << 20);
      return v;
    end
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] rand_cmd();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return CMD_TRAIN;
    end else if (pick < 72) begin
      return CMD_RAW;
    end else if (pick < 95) begin
      return CMD_ACT;
    end
    return CMD_SPARE;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_rate();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return LR_RESET;
      3, 4, 5, 6: return CFG_DATA_W'($urandom_range(1, 2048));
      default: return CFG_DATA_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_mode_word();
    logic [CFG_DATA_W-MODE_W-1:0] upper;
    upper = $urandom_range(1) ? (CFG_DATA_W-MODE_W)'($urandom) : '0;
    return {upper, MODE_W'($urandom_range(3))};
  endfunction

  task automatic test_reset_state();
    send_pattern(CMD_RAW, F_MAX, F_MAX, '0);
    send_pattern(CMD_ACT, F_MIN, F_MIN, '0);
    send_pattern(CMD_SPARE, F_MAX, F_MIN, T_MAX);
    send_pattern(CMD_TRAIN, F_MAX, F_MAX, T_MAX);
    send_pattern(CMD_TRAIN, F_MIN, F_MIN, T_MIN);
    send_pattern(CMD_RAW, 16'sh0100, 16'shFF00, '0);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_reg(REG_LEARNING_RATE, '1);
    write_reg(REG_ACTIVATION_MODE, CFG_DATA_W'(ACT_IDENTITY));
    send_pattern(CMD_RAW, F_MAX, F_MAX, '0);
    send_pattern(CMD_RAW, F_MIN, F_MIN, '0);
    send_pattern(CMD_TRAIN, F_MAX, F_MAX, T_MIN);
    send_pattern(CMD_ACT, F_MAX, F_MAX, '0);
    send_pattern(CMD_TRAIN, F_MAX, F_MIN, T_MAX);
    send_pattern(CMD_RAW, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_activation_modes();
    write_reg(REG_LEARNING_RATE, 16'd4096);
    write_reg(REG_ACTIVATION_MODE, CFG_DATA_W'(ACT_SIGN));
    send_pattern(CMD_ACT, F_MIN, F_MAX, '0);
    send_pattern(CMD_TRAIN, 16'sh0080, 16'shFF80, '0);
    wait_idle();
    // spare mode with upper data bits set falls back to identity
    write_reg(REG_ACTIVATION_MODE, {14'h3FFF, MODE_SPARE});
    send_pattern(CMD_ACT, 16'sh0200, 16'sh0100, '0);
    send_pattern(CMD_TRAIN, 16'sh0200, 16'sh0100, Q_ONE);
    wait_idle();
  endtask

  task automatic test_zero_rate();
    write_reg(REG_LEARNING_RATE, '0);
    write_reg(REG_ACTIVATION_MODE, CFG_DATA_W'(ACT_STEP));
    send_pattern(CMD_TRAIN, F_MAX, F_MIN, T_MAX);
    send_pattern(CMD_RAW, F_MAX, F_MIN, '0);
    send_pattern(CMD_SPARE, F_MIN, F_MAX, T_MIN);
    wait_idle();
  endtask

  task automatic test_backpressure();
    feat_set_t x;
    write_reg(REG_LEARNING_RATE, 16'd300);
    write_reg(REG_ACTIVATION_MODE, CFG_DATA_W'(ACT_IDENTITY));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_request = 150;
    repeat (20) begin
      for (int i = 0; i < NUM_FEAT; i++) begin
        x[i] = rand_feature();
      end
      send_item(rand_cmd(), x, rand_target());
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
    feat_set_t x;
    int        sent;
    int        block_len;
    bit        quiet;
    sent = 0;
    while (sent < count) begin
      wait_idle();
      write_reg(REG_LEARNING_RATE, rand_rate());
      write_reg(REG_ACTIVATION_MODE, rand_mode_word());
      quiet         = ($urandom_range(3) == 0);
      send_idle_pct = quiet ? 0 : snd_pct;
      recv_idle_pct = quiet ? 0 : rcv_pct;
      block_len     = $urandom_range(30, 70);
      for (int j = 0; j < block_len && sent < count; j++) begin
        for (int i = 0; i < NUM_FEAT; i++) begin
          x[i] = rand_feature();
        end
        send_item(rand_cmd(), x, rand_target());
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing pending, value %0d raw %0d",
                 $time, result_value, raw_sum);
      end else begin
        got_want = pending_scores.pop_front();
        if (result_value !== got_want.value) begin
          errors++;
          $display("%0t: result_value expected %0d got %0d",
                   $time, got_want.value, result_value);
        end
        if (raw_sum !== got_want.raw) begin
          errors++;
          $display("%0t: raw_sum expected %0d got %0d", $time, got_want.raw, raw_sum);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    out_ready  = 1'b0;
    cmd_drv    = CMD_RAW;
    target_drv = '0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_LEARNING_RATE;
    cfg_data   = '0;
    for (int i = 0; i < NUM_FEAT; i++) begin
      feat_drv[i] = '0;
      shadow_w[i] = '0;
    end
    shadow_bias = '0;
    shadow_rate = LR_RESET;
    shadow_mode = ACT_STEP;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_saturation();
    test_activation_modes();
    test_zero_rate();
    test_backpressure();
    test_random_traffic(580, 32, 73);
    test_random_traffic(580, 73, 32);
    test_random_traffic(590, 0, 0);

    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
